// ===== rtl/smdm_pkg.sv =====
// shared types and constants for the sorted map diff merge block
package smdm_pkg;

    // default field widths
    localparam int KEY_WIDTH_DEF = 32;
    localparam int REF_WIDTH_DEF = 32;

    // op codes carried with each item
    localparam logic OP_ENTRY = 1'b0;
    localparam logic OP_END   = 1'b1;

    // list sides
    localparam logic SIDE_NEW = 1'b0;
    localparam logic SIDE_OLD = 1'b1;

    // control flags of the merge state
    typedef struct packed {
        logic new_full;
        logic old_full;
        logic new_ended;
        logic old_ended;
    } smdm_flags_t;

endpackage

// ===== rtl/smdm_entry_if.sv =====
// input channel: one list entry or end mark per item
interface smdm_entry_if #(
    parameter int KEY_WIDTH = smdm_pkg::KEY_WIDTH_DEF,
    parameter int REF_WIDTH = smdm_pkg::REF_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic                 side;
    logic [KEY_WIDTH-1:0] entry_key;
    logic [REF_WIDTH-1:0] entry_ref;

    modport source (output valid, op, side, entry_key, entry_ref, input ready);
    modport sink   (input valid, op, side, entry_key, entry_ref, output ready);
endinterface

// ===== rtl/smdm_change_if.sv =====
// output channel: one change record and status per item
interface smdm_change_if #(
    parameter int KEY_WIDTH = smdm_pkg::KEY_WIDTH_DEF,
    parameter int REF_WIDTH = smdm_pkg::REF_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 change_valid;
    logic [KEY_WIDTH-1:0] change_key;
    logic [REF_WIDTH-1:0] change_ref;
    logic                 change_removed;
    logic                 want_side;
    logic                 diff_done;

    modport source (output valid, change_valid, change_key, change_ref, change_removed,
                    want_side, diff_done, input ready);
    modport sink   (input valid, change_valid, change_key, change_ref, change_removed,
                    want_side, diff_done, output ready);
endinterface

// ===== rtl/sorted_map_diff_merge_core.sv =====
// Merge-join diff of two key-sorted lists (new on side 0, previous on side 1).
// Every accepted item gives exactly one result item: it is held in the input
// register, then passes through the key compare into the result register. One
// item is taken per cycle without gaps while the output side is ready; the head
// registers update as each item leaves the input register, so the next item
// sees the state the previous one left. A stalled result holds its register
// while one further item waits in the input register.
module sorted_map_diff_merge_core
    import smdm_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int REF_WIDTH = REF_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    smdm_entry_if.sink    entry,
    smdm_change_if.source result
);

    // input register
    logic                 in_vld_reg;
    logic                 in_vld_next;
    logic                 op_reg;
    logic                 side_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [REF_WIDTH-1:0] ref_reg;

    // merge state
    smdm_flags_t          flags_reg;
    smdm_flags_t          flags_next;
    logic [KEY_WIDTH-1:0] new_key_reg;
    logic [KEY_WIDTH-1:0] new_key_next;
    logic [REF_WIDTH-1:0] new_ref_reg;
    logic [REF_WIDTH-1:0] new_ref_next;
    logic [KEY_WIDTH-1:0] old_key_reg;
    logic [KEY_WIDTH-1:0] old_key_next;
    logic [REF_WIDTH-1:0] old_ref_reg;
    logic [REF_WIDTH-1:0] old_ref_next;

    // result register
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 chg_valid_reg;
    logic [KEY_WIDTH-1:0] chg_key_reg;
    logic [REF_WIDTH-1:0] chg_ref_reg;
    logic                 chg_removed_reg;
    logic                 want_side_reg;
    logic                 done_reg;

    // step outputs
    logic                 step_valid;
    logic [KEY_WIDTH-1:0] step_key;
    logic [REF_WIDTH-1:0] step_ref;
    logic                 step_removed;
    logic                 step_want;
    logic                 step_done;

    logic                 advance;
    logic                 take;
    logic                 accept;

    // handshake control
    assign advance     = !out_vld_reg || result.ready;
    assign take        = in_vld_reg && advance;
    assign entry.ready = !in_vld_reg || advance;
    assign accept      = entry.valid && entry.ready;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (take)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (take)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    smdm_merge_step #(
        .KEY_WIDTH (KEY_WIDTH),
        .REF_WIDTH (REF_WIDTH)
    ) u_step (
        .flags          (flags_reg),
        .new_key        (new_key_reg),
        .new_ref        (new_ref_reg),
        .old_key        (old_key_reg),
        .old_ref        (old_ref_reg),
        .op             (op_reg),
        .side           (side_reg),
        .entry_key      (key_reg),
        .entry_ref      (ref_reg),
        .flags_next     (flags_next),
        .new_key_next   (new_key_next),
        .new_ref_next   (new_ref_next),
        .old_key_next   (old_key_next),
        .old_ref_next   (old_ref_next),
        .change_valid   (step_valid),
        .change_key     (step_key),
        .change_ref     (step_ref),
        .change_removed (step_removed),
        .want_side      (step_want),
        .diff_done      (step_done)
    );

    // control registers and list heads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            flags_reg   <= '0;
            new_key_reg <= '0;
            new_ref_reg <= '0;
            old_key_reg <= '0;
            old_ref_reg <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (take)
            begin
                flags_reg   <= flags_next;
                new_key_reg <= new_key_next;
                new_ref_reg <= new_ref_next;
                old_key_reg <= old_key_next;
                old_ref_reg <= old_ref_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= entry.op;
            side_reg <= entry.side;
            key_reg  <= entry.entry_key;
            ref_reg  <= entry.entry_ref;
        end
        if (take)
        begin
            chg_valid_reg   <= step_valid;
            chg_key_reg     <= step_key;
            chg_ref_reg     <= step_ref;
            chg_removed_reg <= step_removed;
            want_side_reg   <= step_want;
            done_reg        <= step_done;
        end
    end

    // result port
    assign result.valid          = out_vld_reg;
    assign result.change_valid   = chg_valid_reg;
    assign result.change_key     = chg_key_reg;
    assign result.change_ref     = chg_ref_reg;
    assign result.change_removed = chg_removed_reg;
    assign result.want_side      = want_side_reg;
    assign result.diff_done      = done_reg;

    // checks
    a_heads_not_both_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(flags_reg.new_full && flags_reg.old_full))
        else $error("both heads held after a merge step");

    a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg.new_ended || flags_reg.old_ended) |=>
        (!$past(flags_reg.new_ended) || flags_reg.new_ended) &&
        (!$past(flags_reg.old_ended) || flags_reg.old_ended))
        else $error("end of list mark lost");

    a_removed_no_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && chg_removed_reg) |-> (chg_valid_reg && chg_ref_reg == '0))
        else $error("removal carries a reference");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(flags_reg))
        else $error("merge state moved without an item");

endmodule

// ===== rtl/smdm_merge_step.sv =====
// one merge step: load the item into its free head or mark its side ended, then make one merge decision
module smdm_merge_step
    import smdm_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int REF_WIDTH = REF_WIDTH_DEF
) (
    input  smdm_flags_t          flags,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic [REF_WIDTH-1:0] new_ref,
    input  logic [KEY_WIDTH-1:0] old_key,
    input  logic [REF_WIDTH-1:0] old_ref,
    input  logic                 op,
    input  logic                 side,
    input  logic [KEY_WIDTH-1:0] entry_key,
    input  logic [REF_WIDTH-1:0] entry_ref,
    output smdm_flags_t          flags_next,
    output logic [KEY_WIDTH-1:0] new_key_next,
    output logic [REF_WIDTH-1:0] new_ref_next,
    output logic [KEY_WIDTH-1:0] old_key_next,
    output logic [REF_WIDTH-1:0] old_ref_next,
    output logic                 change_valid,
    output logic [KEY_WIDTH-1:0] change_key,
    output logic [REF_WIDTH-1:0] change_ref,
    output logic                 change_removed,
    output logic                 want_side,
    output logic                 diff_done
);

    smdm_flags_t f;

    always_comb
    begin
        f            = flags;
        new_key_next = new_key;
        new_ref_next = new_ref;
        old_key_next = old_key;
        old_ref_next = old_ref;

        // load the item into the head of its side, or mark that side ended
        if (side == SIDE_NEW)
        begin
            if (op == OP_END)
            begin
                f.new_ended = 1'b1;
            end
            else if (!f.new_full && !f.new_ended)
            begin
                new_key_next = entry_key;
                new_ref_next = entry_ref;
                f.new_full   = 1'b1;
            end
        end
        else
        begin
            if (op == OP_END)
            begin
                f.old_ended = 1'b1;
            end
            else if (!f.old_full && !f.old_ended)
            begin
                old_key_next = entry_key;
                old_ref_next = entry_ref;
                f.old_full   = 1'b1;
            end
        end

        // single merge decision
        change_valid   = 1'b0;
        change_key     = '0;
        change_ref     = '0;
        change_removed = 1'b0;
        if (f.new_full && f.old_full)
        begin
            if (new_key_next < old_key_next)
            begin
                change_valid = 1'b1;
                change_key   = new_key_next;
                change_ref   = new_ref_next;
                f.new_full   = 1'b0;
            end
            else if (old_key_next < new_key_next)
            begin
                change_valid   = 1'b1;
                change_key     = old_key_next;
                change_removed = 1'b1;
                f.old_full     = 1'b0;
            end
            else
            begin
                if (new_ref_next != old_ref_next)
                begin
                    change_valid = 1'b1;
                    change_key   = new_key_next;
                    change_ref   = new_ref_next;
                end
                f.new_full = 1'b0;
                f.old_full = 1'b0;
            end
        end
        else if (f.new_full && f.old_ended)
        begin
            change_valid = 1'b1;
            change_key   = new_key_next;
            change_ref   = new_ref_next;
            f.new_full   = 1'b0;
        end
        else if (f.old_full && f.new_ended)
        begin
            change_valid   = 1'b1;
            change_key     = old_key_next;
            change_removed = 1'b1;
            f.old_full     = 1'b0;
        end

        // status after the step
        if (!f.new_full && !f.new_ended)
        begin
            want_side = SIDE_NEW;
        end
        else if (!f.old_full && !f.old_ended)
        begin
            want_side = SIDE_OLD;
        end
        else
        begin
            want_side = SIDE_NEW;
        end
        diff_done  = f.new_ended && f.old_ended && !f.new_full && !f.old_full;
        flags_next = f;
    end

endmodule
